// ===== sv/fpms_pkg.sv =====
// ----------------------------------------------------------------------------
// fpms_pkg: shared types and constants for the front panel mode selector
// Request and result layouts, register indexes, mode codes and reset values.
// ----------------------------------------------------------------------------
package fpms_pkg;

	localparam int TIME_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int CODE_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOOT_TIME        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_WINDOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_POLL_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_HOLDOFF     = 3'd3;

	// register reset values
	localparam logic [TIME_W-1:0] BOOT_TIME_RST        = '0;
	localparam logic [BYTE_W-1:0] STARTUP_WINDOW_RST   = 8'd12;
	localparam logic [BYTE_W-1:0] RESET_POLL_LIMIT_RST = 8'd10;
	localparam logic [BYTE_W-1:0] STEP_HOLDOFF_RST     = 8'd3;

	localparam logic [BYTE_W-1:0] HELD_COUNT_MAX = 8'd255;

	// mode codes
	localparam logic [CODE_W-1:0] MODE_NONE    = 3'd0;
	localparam logic [CODE_W-1:0] MODE_AUTO    = 3'd1;
	localparam logic [CODE_W-1:0] MODE_MANUAL  = 3'd2;
	localparam logic [CODE_W-1:0] MODE_FLASH   = 3'd3;
	localparam logic [CODE_W-1:0] MODE_ALLRED  = 3'd4;
	localparam logic [CODE_W-1:0] MODE_STEP    = 3'd5;

	typedef struct packed {
		logic [TIME_W-1:0] now_seconds;
		logic              step_key_n;
		logic              flash_key_n;
		logic              auto_key_n;
		logic              manual_key_n;
		logic              allred_key_n;
	} poll_t;

	typedef struct packed {
		logic [CODE_W-1:0] mode_code;
		logic              lamps_write;
		logic              step_lamp;
		logic              flash_lamp;
		logic              auto_lamp;
		logic              manual_lamp;
		logic              allred_lamp;
		logic              factory_reset;
	} result_t;

	typedef struct packed {
		logic [TIME_W-1:0] boot_time;
		logic [BYTE_W-1:0] startup_window;
		logic [BYTE_W-1:0] reset_poll_limit;
		logic [BYTE_W-1:0] step_holdoff;
	} cfg_t;

endpackage

// ===== sv/fpms_cfg.sv =====
// ----------------------------------------------------------------------------
// fpms_cfg: configuration register file
// Four writable registers, decoded by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module fpms_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [fpms_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [fpms_pkg::CFG_DATA_W-1:0] wr_data,
	output fpms_pkg::cfg_t                  cfg
);

	fpms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_time        <= fpms_pkg::BOOT_TIME_RST;
			cfg_q.startup_window   <= fpms_pkg::STARTUP_WINDOW_RST;
			cfg_q.reset_poll_limit <= fpms_pkg::RESET_POLL_LIMIT_RST;
			cfg_q.step_holdoff     <= fpms_pkg::STEP_HOLDOFF_RST;
		end else if (wr_en) begin
			case (wr_index)
				fpms_pkg::REG_BOOT_TIME: begin
					cfg_q.boot_time <= wr_data[fpms_pkg::TIME_W-1:0];
				end
				fpms_pkg::REG_STARTUP_WINDOW: begin
					cfg_q.startup_window <= wr_data[fpms_pkg::BYTE_W-1:0];
				end
				fpms_pkg::REG_RESET_POLL_LIMIT: begin
					cfg_q.reset_poll_limit <= wr_data[fpms_pkg::BYTE_W-1:0];
				end
				fpms_pkg::REG_STEP_HOLDOFF: begin
					cfg_q.step_holdoff <= wr_data[fpms_pkg::BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/fpms_logic.sv =====
// ----------------------------------------------------------------------------
// fpms_logic: mode flags, held-key counter and per-poll decision
// Computes the result for the staged poll and commits state when it moves on.
// ----------------------------------------------------------------------------
module fpms_logic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  fpms_pkg::poll_t    poll,
	input  fpms_pkg::cfg_t     cfg,
	output fpms_pkg::result_t  result
);

	logic                        auto_q, manual_q, flash_q, allred_q, step_q;
	logic [fpms_pkg::BYTE_W-1:0] held_q;
	logic [fpms_pkg::TIME_W-1:0] last_step_q;

	logic                        auto_d, manual_d, flash_d, allred_d, step_d;
	logic [fpms_pkg::BYTE_W-1:0] held_d;
	logic                        last_step_we;

	logic [fpms_pkg::TIME_W-1:0] since_boot;
	logic [fpms_pkg::TIME_W-1:0] since_step;
	logic                        in_window;
	logic                        holdoff_ok;
	logic                        step_k, flash_k, auto_k, manual_k, allred_k;
	logic [fpms_pkg::CODE_W-1:0] code;

	assign step_k   = !poll.step_key_n;
	assign flash_k  = !poll.flash_key_n;
	assign auto_k   = !poll.auto_key_n;
	assign manual_k = !poll.manual_key_n;
	assign allred_k = !poll.allred_key_n;

	assign since_boot = poll.now_seconds - cfg.boot_time;
	assign since_step = poll.now_seconds - last_step_q;
	assign in_window  = since_boot < {{(fpms_pkg::TIME_W-fpms_pkg::BYTE_W){1'b0}},
		cfg.startup_window};
	assign holdoff_ok = since_step > {{(fpms_pkg::TIME_W-fpms_pkg::BYTE_W){1'b0}},
		cfg.step_holdoff};

	always_comb begin
		auto_d       = auto_q;
		manual_d     = manual_q;
		flash_d      = flash_q;
		allred_d     = allred_q;
		step_d       = step_q;
		held_d       = held_q;
		last_step_we = 1'b0;
		code         = fpms_pkg::MODE_NONE;
		result       = '0;

		if (in_window) begin
			if (flash_k && held_q != fpms_pkg::HELD_COUNT_MAX) begin
				held_d = held_q + 8'd1;
			end
			result.factory_reset = held_d >= cfg.reset_poll_limit;
		end else begin
			if (auto_q) begin
				if (manual_k) begin
					auto_d   = 1'b0;
					manual_d = 1'b1;
					code     = fpms_pkg::MODE_MANUAL;
				end
			end else if (manual_q) begin
				if (auto_k) begin
					auto_d   = 1'b1;
					manual_d = 1'b0;
					flash_d  = 1'b0;
					step_d   = 1'b0;
					allred_d = 1'b0;
					code     = fpms_pkg::MODE_AUTO;
				end else if (flash_k) begin
					flash_d  = 1'b1;
					step_d   = 1'b0;
					allred_d = 1'b0;
					code     = fpms_pkg::MODE_FLASH;
				end else if (allred_k) begin
					allred_d = 1'b1;
					flash_d  = 1'b0;
					step_d   = 1'b0;
					code     = fpms_pkg::MODE_ALLRED;
				end else if (step_k && !flash_q && !allred_q && holdoff_ok) begin
					last_step_we = 1'b1;
					step_d       = 1'b1;
					code         = fpms_pkg::MODE_STEP;
				end
			end
			// every accepted key writes all five lamps from the new flags
			if (code != fpms_pkg::MODE_NONE) begin
				result.mode_code   = code;
				result.lamps_write = 1'b1;
				result.step_lamp   = step_d;
				result.flash_lamp  = flash_d;
				result.auto_lamp   = auto_d;
				result.manual_lamp = manual_d;
				result.allred_lamp = allred_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q      <= 1'b1;
			manual_q    <= 1'b0;
			flash_q     <= 1'b0;
			allred_q    <= 1'b0;
			step_q      <= 1'b0;
			held_q      <= '0;
			last_step_q <= '0;
		end else if (fire) begin
			auto_q   <= auto_d;
			manual_q <= manual_d;
			flash_q  <= flash_d;
			allred_q <= allred_d;
			step_q   <= step_d;
			held_q   <= held_d;
			if (last_step_we) begin
				last_step_q <= poll.now_seconds;
			end
		end
	end

	// auto and manual are never on together
	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(auto_q && manual_q))
		else $error("auto and manual flags both set");

	// flashing and all-red are never on together
	a_flash_allred_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(flash_q && allred_q))
		else $error("flashing and all-red flags both set");

	// an accepted step records its poll time
	a_step_time: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_step_we |=> last_step_q == $past(poll.now_seconds))
		else $error("step time not captured");

	// held counter never changes outside the startup window
	a_held_window: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !in_window |=> $stable(held_q))
		else $error("held counter moved outside window");

endmodule

// ===== sv/front_panel_mode_selector_core.sv =====
// ----------------------------------------------------------------------------
// front_panel_mode_selector_core: front panel key poller and mode selector
// Takes key polls, tracks panel mode and startup factory-reset key holds.
//
//   channel  direction  handshake           payload
//   in       request    in_valid/in_stall   in_data   (fpms_pkg::poll_t)
//   out      result     out_valid/out_stall out_data  (fpms_pkg::result_t)
//   cfg      write      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request per cycle, sustained while out_stall is low. A request held in the
// input register is decided in one pass of shallow logic, and its result is
// loaded into the result register once that register is free.
// Mode flags and counters update as the request leaves the input register, so
// the following request sees them.
// out_stall holds the result register; the input register then fills and
// in_stall rises. Reset is asynchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
module front_panel_mode_selector_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  fpms_pkg::poll_t                 in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output fpms_pkg::result_t               out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fpms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpms_pkg::CFG_DATA_W-1:0] cfg_data
);

	fpms_pkg::cfg_t    cfg;
	fpms_pkg::poll_t   poll_s1;
	logic              valid_s1;
	fpms_pkg::result_t result;
	fpms_pkg::result_t result_q;
	logic              out_valid_q;

	logic out_free;  // result register can take a new value
	logic fire;      // staged request moves to the result register
	logic load;      // new request accepted

	assign cfg_ready = 1'b1;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign load     = in_valid && !in_stall;

	fpms_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fpms_logic u_logic (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.poll   (poll_s1),
		.cfg    (cfg),
		.result (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			poll_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// a stall on the input side only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a held result");

	// factory reset never comes with a lamp write
	a_fr_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data.factory_reset |-> !out_data.lamps_write)
		else $error("factory reset together with lamp write");

	// a lamp write carries a mode code, and only then
	a_write_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |->
			out_data.lamps_write == (out_data.mode_code != fpms_pkg::MODE_NONE))
		else $error("lamp write and mode code disagree");

endmodule

// ===== test/front_panel_mode_selector_core_tb.sv =====
// ----------------------------------------------------------------------------
// front_panel_mode_selector_core_tb: self-checking bench for the panel poller
// Drives key polls and register writes into the core, predicts every result
// with an independent model of the mode flags, hold counter and step holdoff,
// and compares each result field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module front_panel_mode_selector_core_tb;

	// pressed-key masks, ordered as in the poll request (step..allred)
	localparam logic [4:0] K_NONE   = 5'b00000;
	localparam logic [4:0] K_STEP   = 5'b10000;
	localparam logic [4:0] K_FLASH  = 5'b01000;
	localparam logic [4:0] K_AUTO   = 5'b00100;
	localparam logic [4:0] K_MANUAL = 5'b00010;
	localparam logic [4:0] K_ALLRED = 5'b00001;
	localparam logic [4:0] K_ALL    = 5'b11111;

	localparam int LONG_HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES     = 4;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	fpms_pkg::poll_t                 in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	fpms_pkg::result_t               out_data;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [fpms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fpms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	front_panel_mode_selector_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 20 unit period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predicted panel state and register copies
	// ------------------------------------------------------------------
	logic                        auto_mode        = 1'b1;
	logic                        manual_mode      = 1'b0;
	logic                        flash_mode       = 1'b0;
	logic                        allred_mode      = 1'b0;
	logic                        step_mode        = 1'b0;
	logic [fpms_pkg::BYTE_W-1:0] flash_hold_polls = '0;
	logic [fpms_pkg::TIME_W-1:0] last_step_sec    = '0;

	logic [fpms_pkg::TIME_W-1:0] boot_sec         = fpms_pkg::BOOT_TIME_RST;
	logic [fpms_pkg::BYTE_W-1:0] window_sec       = fpms_pkg::STARTUP_WINDOW_RST;
	logic [fpms_pkg::BYTE_W-1:0] reset_hold_limit = fpms_pkg::RESET_POLL_LIMIT_RST;
	logic [fpms_pkg::BYTE_W-1:0] step_gap_sec     = fpms_pkg::STEP_HOLDOFF_RST;

	fpms_pkg::result_t pending_results[$];

	// bench control and tallies
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_request = 1'b0;
	int mismatches = 0;
	int polls_sent = 0;
	int results_checked = 0;
	int wipes_seen = 0;
	int steps_seen = 0;
	int settings_applied = 0;

	// Works out the result of one accepted poll and advances the panel state.
	function automatic fpms_pkg::result_t next_panel_result(fpms_pkg::poll_t p);
		fpms_pkg::result_t           r;
		logic [fpms_pkg::CODE_W-1:0] code;
		logic                        step_k, flash_k, auto_k, manual_k, allred_k;
		logic [fpms_pkg::TIME_W-1:0] since_boot;
		logic [fpms_pkg::TIME_W-1:0] since_step;
		r = '0;
		code = fpms_pkg::MODE_NONE;
		step_k   = !p.step_key_n;
		flash_k  = !p.flash_key_n;
		auto_k   = !p.auto_key_n;
		manual_k = !p.manual_key_n;
		allred_k = !p.allred_key_n;
		since_boot = p.now_seconds - boot_sec;
		since_step = p.now_seconds - last_step_sec;

		// startup window: only count held flashing key, maybe request wipe
		if (since_boot < {24'd0, window_sec}) begin
			if (flash_k && flash_hold_polls != fpms_pkg::HELD_COUNT_MAX)
				flash_hold_polls++;
			r.factory_reset = (flash_hold_polls >= reset_hold_limit);
			return r;
		end

		// auto flag wins over manual flag
		if (auto_mode) begin
			if (manual_k) begin
				auto_mode = 1'b0;
				manual_mode = 1'b1;
				code = fpms_pkg::MODE_MANUAL;
			end
		end else if (manual_mode) begin
			if (auto_k) begin
				auto_mode = 1'b1;
				manual_mode = 1'b0;
				flash_mode = 1'b0;
				step_mode = 1'b0;
				allred_mode = 1'b0;
				code = fpms_pkg::MODE_AUTO;
			end else if (flash_k) begin
				flash_mode = 1'b1;
				auto_mode = 1'b0;
				step_mode = 1'b0;
				allred_mode = 1'b0;
				code = fpms_pkg::MODE_FLASH;
			end else if (allred_k) begin
				allred_mode = 1'b1;
				flash_mode = 1'b0;
				auto_mode = 1'b0;
				step_mode = 1'b0;
				code = fpms_pkg::MODE_ALLRED;
			end else if (step_k && !flash_mode && !allred_mode &&
					since_step > {24'd0, step_gap_sec}) begin
				last_step_sec = p.now_seconds;
				step_mode = 1'b1;
				allred_mode = 1'b0;
				flash_mode = 1'b0;
				auto_mode = 1'b0;
				code = fpms_pkg::MODE_STEP;
			end
		end

		if (code != fpms_pkg::MODE_NONE) begin
			r.mode_code   = code;
			r.lamps_write = 1'b1;
			r.step_lamp   = step_mode;
			r.flash_lamp  = flash_mode;
			r.auto_lamp   = auto_mode;
			r.manual_lamp = manual_mode;
			r.allred_lamp = allred_mode;
		end
		return r;
	endfunction

	function automatic fpms_pkg::poll_t mk_poll(logic [fpms_pkg::TIME_W-1:0] t,
			logic [4:0] pressed);
		fpms_pkg::poll_t p;
		p.now_seconds = t;
		{p.step_key_n, p.flash_key_n, p.auto_key_n, p.manual_key_n, p.allred_key_n} =
			~pressed;
		return p;
	endfunction

	// Key mix biased toward step presses, with enough auto/manual to cycle modes.
	function automatic logic [4:0] pick_keys();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 14) return K_MANUAL;
		if (sel < 22) return K_AUTO;
		if (sel < 34) return K_FLASH;
		if (sel < 46) return K_ALLRED;
		if (sel < 86) return K_STEP;
		if (sel < 94) return K_NONE;
		return 5'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// Request side. Every task is entered and left at a falling edge with no
	// assignment yet made in that step, so valid is never lowered and raised
	// in the same step.
	// ------------------------------------------------------------------
	task automatic send_poll(fpms_pkg::poll_t p);
		int gap;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		// request taken on the first rising edge with stall low
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		pending_results.push_back(next_panel_result(p));
		polls_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [fpms_pkg::CFG_IDX_W-1:0] idx,
			logic [fpms_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		case (idx)
			fpms_pkg::REG_BOOT_TIME:        boot_sec = value;
			fpms_pkg::REG_STARTUP_WINDOW:   window_sec = value[fpms_pkg::BYTE_W-1:0];
			fpms_pkg::REG_RESET_POLL_LIMIT: reset_hold_limit = value[fpms_pkg::BYTE_W-1:0];
			fpms_pkg::REG_STEP_HOLDOFF:     step_gap_sec = value[fpms_pkg::BYTE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait for every predicted result to come out, then wait out the drain period.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apply_settings(logic [fpms_pkg::TIME_W-1:0] boot,
			logic [fpms_pkg::BYTE_W-1:0] win, logic [fpms_pkg::BYTE_W-1:0] lim,
			logic [fpms_pkg::BYTE_W-1:0] gap);
		settle_idle();
		write_reg(fpms_pkg::REG_BOOT_TIME, boot);
		write_reg(fpms_pkg::REG_STARTUP_WINDOW, {24'd0, win});
		write_reg(fpms_pkg::REG_RESET_POLL_LIMIT, {24'd0, lim});
		write_reg(fpms_pkg::REG_STEP_HOLDOFF, {24'd0, gap});
		settings_applied++;
	endtask

	// ------------------------------------------------------------------
	// Result side: stall generator and checker
	// ------------------------------------------------------------------
	initial begin : rx_stall_gen
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				// long hold-off: core fills and pushes back on requests
				hold_request = 1'b0;
				stall_left = LONG_HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [fpms_pkg::TIME_W-1:0] want,
			logic [fpms_pkg::TIME_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	fpms_pkg::result_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no poll outstanding: %h", out_data);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("mode_code", want.mode_code, out_data.mode_code);
				check_field("lamps_write", want.lamps_write, out_data.lamps_write);
				check_field("step_lamp", want.step_lamp, out_data.step_lamp);
				check_field("flash_lamp", want.flash_lamp, out_data.flash_lamp);
				check_field("auto_lamp", want.auto_lamp, out_data.auto_lamp);
				check_field("manual_lamp", want.manual_lamp, out_data.manual_lamp);
				check_field("allred_lamp", want.allred_lamp, out_data.allred_lamp);
				check_field("factory_reset", want.factory_reset, out_data.factory_reset);
				results_checked++;
				if (want.factory_reset) wipes_seen++;
				if (want.mode_code == fpms_pkg::MODE_STEP) steps_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset registers: boot 0, window 12, limit 10. Ten held polls trip the wipe,
	// which then repeats for the rest of the window.
	task automatic test_startup_hold();
		int i;
		send_poll(mk_poll(32'd0, K_NONE));
		for (i = 0; i < 11; i++)
			send_poll(mk_poll(32'd5, K_FLASH));
		send_poll(mk_poll(32'd11, K_NONE));     // last second of the window
		send_poll(mk_poll(32'd12, K_FLASH));    // first second outside, auto ignores it
	endtask

	// Mode walk with reset registers, all times well past the window.
	task automatic test_mode_keys();
		send_poll(mk_poll(32'd100, K_NONE));
		send_poll(mk_poll(32'd100, K_AUTO));    // auto mode looks only at manual
		send_poll(mk_poll(32'd101, K_ALL));
		send_poll(mk_poll(32'd102, K_MANUAL));  // manual key unused in manual mode
		send_poll(mk_poll(32'd103, K_ALL));     // auto key first in manual mode
		send_poll(mk_poll(32'd104, K_MANUAL));
		send_poll(mk_poll(32'd105, K_STEP));
		send_poll(mk_poll(32'd107, K_STEP));    // inside holdoff
		send_poll(mk_poll(32'd108, K_STEP));    // exactly the holdoff, still refused
		send_poll(mk_poll(32'd109, K_STEP));
		send_poll(mk_poll(32'd110, K_FLASH | K_ALLRED | K_STEP));
		send_poll(mk_poll(32'd200, K_STEP));    // blocked by flashing
		send_poll(mk_poll(32'd201, K_ALLRED | K_STEP));
		send_poll(mk_poll(32'd300, K_STEP));    // blocked by all-red
		send_poll(mk_poll(32'd301, K_FLASH));
		send_poll(mk_poll(32'd302, K_AUTO));
		send_poll(mk_poll(32'd303, K_MANUAL));
		send_poll(mk_poll(32'd400, K_STEP));
		send_poll(mk_poll(32'd401, K_NONE));
	endtask

	// Register extremes, window edges across the 2^32 wrap, holdoff 0 and 255.
	task automatic test_register_extremes();
		apply_settings(32'hFFFF_FFF0, 8'd255, 8'd255, 8'd0);
		send_poll(mk_poll(32'hFFFF_FFF0, K_STEP));
		send_poll(mk_poll(32'hFFFF_FFF5, K_FLASH));
		send_poll(mk_poll(32'h0000_00EE, K_STEP));  // 254 s after boot, inside
		send_poll(mk_poll(32'h0000_00EF, K_STEP));  // 255 s, outside
		send_poll(mk_poll(32'h0000_00F0, K_STEP));  // one second past, holdoff 0
		send_poll(mk_poll(32'h0000_00F0, K_STEP));  // same second, refused

		apply_settings(32'd0, 8'd0, 8'd1, 8'd255);  // empty window
		send_poll(mk_poll(32'd0, K_FLASH));
		send_poll(mk_poll(32'd1, K_AUTO));
		send_poll(mk_poll(32'd2, K_MANUAL));
		send_poll(mk_poll(32'hFFFF_FFFF, K_STEP));
		send_poll(mk_poll(32'h0000_00FE, K_STEP));  // 255 s across the wrap
		send_poll(mk_poll(32'h0000_00FF, K_STEP));  // 256 s

		apply_settings(32'h8000_0000, 8'd1, 8'd1, 8'd3);
		send_poll(mk_poll(32'h8000_0000, K_NONE));  // count already above limit
		send_poll(mk_poll(32'h8000_0001, K_NONE));
		send_poll(mk_poll(32'h7FFF_FFFF, K_FLASH)); // one second before boot
	endtask

	// Receiver holds off while requests keep coming.
	task automatic test_backpressure();
		logic [fpms_pkg::TIME_W-1:0] t;
		int i;
		apply_settings(32'd0, 8'd0, 8'd10, 8'd0);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_request = 1'b1;
		t = 32'd5000;
		for (i = 0; i < 30; i++) begin
			t = t + 1;
			send_poll(mk_poll(t, pick_keys()));
		end
		settle_idle();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Random settings per phase, time walking forward from near boot so each
	// phase passes through its window; a share of polls is raw noise.
	task automatic test_random_traffic(int phases, int polls_per_phase);
		logic [fpms_pkg::TIME_W-1:0] boot, t;
		logic [fpms_pkg::BYTE_W-1:0] win, lim, gap;
		int ph, i;
		for (ph = 0; ph < phases; ph++) begin
			boot = $urandom;
			case ($urandom_range(0, 3))
				0: win = 8'd0;
				1: win = 8'd255;
				default: win = 8'($urandom_range(1, 20));
			endcase
			case ($urandom_range(0, 3))
				0: lim = 8'd1;
				1: lim = 8'd255;
				default: lim = 8'($urandom_range(2, 40));
			endcase
			gap = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
			apply_settings(boot, win, lim, gap);
			t = boot + $urandom_range(0, win);
			for (i = 0; i < polls_per_phase; i++) begin
				if ($urandom_range(0, 99) < 8) begin
					send_poll(mk_poll($urandom, 5'($urandom)));
				end else begin
					t = t + $urandom_range(0, 3);
					send_poll(mk_poll(t, pick_keys()));
				end
			end
		end
	endtask

	// Long run of held polls: counter must stick at 255, not wrap.
	task automatic test_hold_saturation();
		int i;
		apply_settings(32'h1234_5678, 8'd255, 8'd255, 8'd3);
		for (i = 0; i < 270; i++)
			send_poll(mk_poll(32'h1234_5678, K_FLASH));
		send_poll(mk_poll(32'h1234_5678 + 32'd255, K_NONE));
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_startup_hold();
		test_mode_keys();
		test_register_extremes();
		test_backpressure();
		test_random_traffic(6, 250);
		test_hold_saturation();

		// closing stretch with no idling on either side
		settle_idle();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random_traffic(1, 250);

		settle_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d polls under %0d register settings, checked %0d results",
			polls_sent, settings_applied, results_checked);
		$display("including %0d factory-reset and %0d step results, %0d mismatches",
			wipes_seen, steps_seen, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("Timeout with %0d results still outstanding", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
